[hdl/ftc_pkg.sv]
// Package for the fragment coverage tracker.
// Holds field widths, reset values, status codes and the payload and control structs.
// No dependencies.
package ftc_pkg;

  localparam int OffsetW = 24;
  localparam int LengthW = 16;
  localparam int CountW  = 5;

  localparam int MaxIntervalsDefault = 16;

  localparam logic [OffsetW-1:0] ChunkSizeReset = 24'd1024;

  // result status codes
  typedef enum logic [1:0] {
    StAccepted  = 2'd0,
    StListFull  = 2'd1,
    StBeyondEnd = 2'd2
  } status_e;

  // one interval [start, stop)
  typedef struct packed {
    logic [OffsetW-1:0] start;
    logic [OffsetW-1:0] stop;
  } ival_t;

  typedef struct packed {
    logic               begin_chunk;
    logic [OffsetW-1:0] frag_offset;
    logic [LengthW-1:0] frag_length;
  } in_item_t;

  typedef struct packed {
    logic              chunk_complete;
    logic [CountW-1:0] interval_count;
    status_e           status;
  } out_item_t;

  // controls shared by every cell of the chain
  typedef struct packed {
    logic rotate;
    logic emit;
    logic commit;
  } cell_ctl_t;

  // controls of the merge unit
  typedef struct packed {
    logic init;
    logic step;
    logic valid;
    logic last;
  } merge_ctl_t;

  // interval leaving the merge unit
  typedef struct packed {
    logic  valid;
    ival_t ival;
  } emit_t;

endpackage

[hdl/ftc_cell.sv]
// One cell of the interval chain: a list entry that rotates and a scratch entry that shifts.
// Depends on ftc_pkg.
module ftc_cell (
  input  logic              clk_i,
  input  ftc_pkg::cell_ctl_t ctl_i,
  input  ftc_pkg::ival_t    list_i,
  input  ftc_pkg::ival_t    scr_i,
  output ftc_pkg::ival_t    list_o,
  output ftc_pkg::ival_t    scr_o
);

  ftc_pkg::ival_t list_q;
  ftc_pkg::ival_t scr_q;

  // rotate the list, or take the rebuilt entry on commit
  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) begin
      list_q <= scr_q;
    end else if (ctl_i.rotate) begin
      list_q <= list_i;
    end
  end

  // shift the scratch row when the merge unit emits
  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      scr_q <= scr_i;
    end
  end

  assign list_o = list_q;
  assign scr_o  = scr_q;

endmodule

[hdl/ftc_merge.sv]
// Merge unit at the end of the interval chain: folds the new fragment into the list,
// which it sees from the highest interval down. Depends on ftc_pkg.
module ftc_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ftc_pkg::merge_ctl_t ctl_i,
  input  ftc_pkg::ival_t      frag_i,
  input  ftc_pkg::ival_t      entry_i,
  output ftc_pkg::emit_t      emit_o
);

  ftc_pkg::ival_t hold_q, hold_d;
  logic           placed_q, placed_d;

  // decide what leaves the unit and what it keeps
  always_comb begin
    hold_d      = hold_q;
    placed_d    = placed_q;
    emit_o      = '0;
    emit_o.ival = hold_q;
    if (ctl_i.init) begin
      hold_d   = frag_i;
      placed_d = 1'b0;
    end else if (ctl_i.step && ctl_i.valid) begin
      if (placed_q) begin
        // pass the remaining lower intervals through, one behind
        emit_o.valid = 1'b1;
        hold_d       = entry_i;
      end else if (entry_i.start > hold_q.stop) begin
        // interval lies above the fragment
        emit_o.valid = 1'b1;
        emit_o.ival  = entry_i;
      end else if (entry_i.stop < hold_q.start) begin
        // first interval below: place the merged fragment
        emit_o.valid = 1'b1;
        hold_d       = entry_i;
        placed_d     = 1'b1;
      end else begin
        // overlapping or touching: join
        if (entry_i.start < hold_q.start) hold_d.start = entry_i.start;
        if (entry_i.stop > hold_q.stop) hold_d.stop = entry_i.stop;
      end
    end else if (ctl_i.last) begin
      emit_o.valid = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      placed_q <= 1'b0;
    end else begin
      placed_q <= placed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
  end

endmodule

[hdl/fragment_coverage_tracker.sv]
// Top level of the fragment coverage tracker: control sequencer, cell chain and merge unit.
// Depends on ftc_pkg, ftc_cell and ftc_merge.
//
// Tracks which byte ranges of one chunk have arrived as a sorted list of up to MaxIntervals
// disjoint intervals held in a chain of cells. For a fragment that needs merging, the list
// rotates once around the cell chain past the merge unit, one interval per cycle; then the
// merge unit is flushed, the result is committed and written, and the sequencer returns to
// idle, where the next fragment is taken. Empty fragments and fragments beyond the chunk end
// skip the rotation and go straight to writing the result. The commit step waits while a
// stalled result still holds the output register. One fragment is processed at a time; the
// next is taken while a finished result waits in the output register. Results come in order,
// one per fragment.
module fragment_coverage_tracker #(
  parameter int MaxIntervals = ftc_pkg::MaxIntervalsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ftc_pkg::OffsetW-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ftc_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ftc_pkg::out_item_t            out_data_o
);

  localparam int CntW = $clog2(MaxIntervals + 2);
  localparam logic [CntW-1:0] NCnt      = CntW'(MaxIntervals);
  localparam logic [CntW-1:0] NPlusOne  = CntW'(MaxIntervals + 1);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish
  } state_e;

  state_e                       state_q, state_d;
  logic [ftc_pkg::OffsetW-1:0]  chunk_q, chunk_d;
  logic [CntW-1:0]              used_q, used_d;
  logic [CntW-1:0]              step_q, step_d;
  logic [CntW-1:0]              emit_cnt_q, emit_cnt_d;
  logic                         done_q, done_d;
  logic                         scan_q, scan_d;
  ftc_pkg::status_e             status_q, status_d;
  logic                         out_valid_q, out_valid_d;
  ftc_pkg::out_item_t           out_q, out_d;

  ftc_pkg::cell_ctl_t           cell_ctl;
  ftc_pkg::merge_ctl_t          merge_ctl;
  ftc_pkg::emit_t               emit;
  ftc_pkg::ival_t               frag;
  ftc_pkg::ival_t               list_w [MaxIntervals];
  ftc_pkg::ival_t               scr_w  [MaxIntervals];

  logic [ftc_pkg::OffsetW:0]    frag_sum;
  logic                         in_xfer;
  logic                         out_free;
  logic                         commit;
  logic [CntW-1:0]              fin_cnt;
  ftc_pkg::ival_t               fin_head;
  logic [CntW+ftc_pkg::CountW-1:0] cnt_ext;

  // fragment end, one bit wider to catch overflow past the chunk
  assign frag_sum   = {1'b0, in_data_i.frag_offset}
                    + {{(ftc_pkg::OffsetW + 1 - ftc_pkg::LengthW){1'b0}}, in_data_i.frag_length};
  assign frag.start = in_data_i.frag_offset;
  assign frag.stop  = frag_sum[ftc_pkg::OffsetW-1:0];

  assign in_xfer  = in_valid_i && (state_q == StIdle);
  assign out_free = !out_valid_q || !out_stall_i;

  // sequence one fragment through the chain
  always_comb begin
    state_d     = state_q;
    chunk_d     = cfg_we_i ? cfg_wdata_i : chunk_q;
    used_d      = used_q;
    step_d      = step_q;
    emit_cnt_d  = emit_cnt_q;
    done_d      = done_q;
    scan_d      = scan_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    cell_ctl    = '0;
    merge_ctl   = '0;
    commit      = 1'b0;
    fin_cnt     = used_q;
    fin_head    = list_w[0];
    cnt_ext     = '0;

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (in_data_i.begin_chunk) begin
            used_d = '0;
            done_d = 1'b0;
          end
          step_d     = '0;
          emit_cnt_d = '0;
          status_d   = ftc_pkg::StAccepted;
          if (in_data_i.frag_length == '0) begin
            scan_d  = 1'b0;
            state_d = StFinish;
          end else if (frag_sum > {1'b0, chunk_q}) begin
            scan_d   = 1'b0;
            status_d = ftc_pkg::StBeyondEnd;
            state_d  = StFinish;
          end else begin
            scan_d         = 1'b1;
            merge_ctl.init = 1'b1;
            state_d        = StScan;
          end
        end
      end

      StScan: begin
        if (step_q == NCnt) begin
          // flush the interval still held in the merge unit
          merge_ctl.last = 1'b1;
          state_d        = StFinish;
        end else begin
          cell_ctl.rotate = 1'b1;
          merge_ctl.step  = 1'b1;
          merge_ctl.valid = ({1'b0, step_q} + {1'b0, used_q}) >= {1'b0, NCnt};
          step_d          = step_q + 1'b1;
        end
        cell_ctl.emit = emit.valid;
        if (emit.valid && (emit_cnt_q != NPlusOne)) begin
          emit_cnt_d = emit_cnt_q + 1'b1;
        end
      end

      StFinish: begin
        if (out_free) begin
          commit          = scan_q && (emit_cnt_q <= NCnt);
          cell_ctl.commit = commit;
          if (commit) begin
            fin_cnt  = emit_cnt_q;
            fin_head = scr_w[0];
          end
          used_d = fin_cnt;
          done_d = done_q || ((fin_cnt != '0) && (fin_head.start == '0)
                              && (fin_head.stop == chunk_q));
          cnt_ext                  = {{ftc_pkg::CountW{1'b0}}, fin_cnt};
          out_d.chunk_complete     = done_d;
          out_d.interval_count     = cnt_ext[ftc_pkg::CountW-1:0];
          out_d.status             = (scan_q && !commit) ? ftc_pkg::StListFull : status_q;
          out_valid_d              = 1'b1;
          state_d                  = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  // hold state, counters, register and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      chunk_q     <= ftc_pkg::ChunkSizeReset;
      used_q      <= '0;
      step_q      <= '0;
      emit_cnt_q  <= '0;
      done_q      <= 1'b0;
      scan_q      <= 1'b0;
      status_q    <= ftc_pkg::StAccepted;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      chunk_q     <= chunk_d;
      used_q      <= used_d;
      step_q      <= step_d;
      emit_cnt_q  <= emit_cnt_d;
      done_q      <= done_d;
      scan_q      <= scan_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // merge unit reads the last cell of the chain
  ftc_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (merge_ctl),
    .frag_i  (frag),
    .entry_i (list_w[MaxIntervals-1]),
    .emit_o  (emit)
  );

  // chain of cells: list rotates toward the end, scratch fills from the head
  for (genvar i = 0; i < MaxIntervals; i++) begin : g_cell
    ftc_pkg::ival_t list_in;
    ftc_pkg::ival_t scr_in;
    if (i == 0) begin : g_head
      assign list_in = list_w[MaxIntervals-1];
      assign scr_in  = emit.ival;
    end else begin : g_body
      assign list_in = list_w[i-1];
      assign scr_in  = scr_w[i-1];
    end
    ftc_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (cell_ctl),
      .list_i (list_in),
      .scr_i  (scr_in),
      .list_o (list_w[i]),
      .scr_o  (scr_w[i])
    );
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hdl/ftc_checker.sv]
// Port-level checker for the fragment coverage tracker, bound to the top level.
// Depends on ftc_pkg and fragment_coverage_tracker.
module ftc_checker #(
  parameter int MaxIntervals = ftc_pkg::MaxIntervalsDefault
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input ftc_pkg::out_item_t          out_data_o
);

  localparam logic [ftc_pkg::CountW-1:0] FullCount = ftc_pkg::CountW'(MaxIntervals);

  // one fragment in flight: stall right after an input transfer
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a fragment is still in work");

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // a drop for lack of room only happens with a full list
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ftc_pkg::StListFull)
      |-> out_data_o.interval_count == FullCount)
    else $error("list-full drop with list not full");

  // completion needs at least one interval in the list
  a_complete_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.chunk_complete && (MaxIntervals < 32)
      |-> out_data_o.interval_count != '0)
    else $error("completion reported with no intervals");

endmodule

bind fragment_coverage_tracker ftc_checker #(.MaxIntervals(MaxIntervals)) u_ftc_checker (.*);
